/* src/radix_digit_emitter_assert.svh */
// ----------------------------------------------------------------------------
// radix_digit_emitter_assert.svh
// Assertion macros for the radix digit emitter.
// ----------------------------------------------------------------------------
`ifndef RADIX_DIGIT_EMITTER_ASSERT_SVH
`define RADIX_DIGIT_EMITTER_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define RDE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define RDE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/rde_pkg.sv */
// ----------------------------------------------------------------------------
// rde_pkg
// Shared constants, types and helpers of the radix digit emitter.
// ----------------------------------------------------------------------------
package rde_pkg;

    localparam int VALUE_BITS_DEF = 31;
    localparam int DIGIT_STEP     = 8;
    localparam int IN_WIDTH       = 32;
    localparam int RADIX_WIDTH    = 6;
    localparam int DIGIT_WIDTH    = 6;
    localparam int CHAR_WIDTH     = 7;

    localparam logic [RADIX_WIDTH-1:0] RADIX_MIN  = 6'd2;
    localparam logic [RADIX_WIDTH-1:0] RADIX_MAX  = 6'd36;
    localparam logic [DIGIT_WIDTH-1:0] DEC_DIGITS = 6'd10;
    localparam logic [CHAR_WIDTH-1:0]  ASCII_ZERO = 7'h30;
    localparam logic [CHAR_WIDTH-1:0]  ASCII_A    = 7'h61;

    typedef struct packed {
        logic load;
        logic step;
        logic wr;
        logic rd;
        logic rd_last;
        logic err;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic chunk_last;
        logic quo_zero;
        logic cnt_one;
    } t_sts;

    function automatic logic [CHAR_WIDTH-1:0] to_ascii(input logic [DIGIT_WIDTH-1:0] d);
        logic [CHAR_WIDTH-1:0] c;
        if (d < DEC_DIGITS) begin
            c = ASCII_ZERO + CHAR_WIDTH'(d);
        end else begin
            c = ASCII_A + CHAR_WIDTH'(d - DEC_DIGITS);
        end
        return c;
    endfunction

endpackage

/* src/radix_digit_emitter.sv */
// ----------------------------------------------------------------------------
// radix_digit_emitter
// Converts a non-negative integer into ASCII digits of radix 2..36.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_value and i_radix and raise start; the item is taken at a
//   clock edge where start is high and busy is low.
//   Each digit comes out as a one-cycle o_strobe with o_digit_char, most
//   significant digit first; o_last marks the final digit of the item.
//   A negative value, a radix outside 2..36 or a value wider than
//   VALUE_BITS gives a single transfer with o_error and o_last set and
//   o_digit_char zero, in the cycle after acceptance; busy stays low then.
//   Otherwise the radix divider (8 quotient bits per cycle) produces the
//   digits one after another into the digit store, then the stored
//   digits are read out one per cycle. An item has at most VALUE_BITS
//   digits (31 for radix 2 at the default width).
//   The next item may be taken in the cycle the last digit is shown.
//   The receiver cannot stall: every strobe is one transfer.
//   Reset (i_rst_n low, synchronous) returns the sequencer to idle and
//   drops any item in flight.
// ----------------------------------------------------------------------------
`include "radix_digit_emitter_assert.svh"

module radix_digit_emitter #(
    parameter int VALUE_BITS = rde_pkg::VALUE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [rde_pkg::IN_WIDTH-1:0] i_value,
    input  logic [rde_pkg::RADIX_WIDTH-1:0]     i_radix,
    output logic                                o_strobe,
    output logic [rde_pkg::CHAR_WIDTH-1:0]      o_digit_char,
    output logic                                o_last,
    output logic                                o_error
);

    rde_pkg::t_cmd s_cmd;
    rde_pkg::t_sts s_sts;

    rde_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (s_sts),
        .o_cmd   (s_cmd)
    );

    rde_dpath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_value      (i_value),
        .i_radix      (i_radix),
        .i_cmd        (s_cmd),
        .o_sts        (s_sts),
        .o_digit_char (o_digit_char),
        .o_last       (o_last),
        .o_error      (o_error),
        .o_strobe     (o_strobe)
    );

    `RDE_ASSERT_NEXT(a_bad_gives_error, start && !busy && s_sts.bad, o_strobe && o_error && o_last && !busy, "rejected input did not give a single error transfer")
    `RDE_ASSERT_NEXT(a_good_starts_div, start && !busy && !s_sts.bad, busy && !o_strobe, "accepted input did not start conversion")
    `RDE_ASSERT_NOW(a_digit_nonzero, o_strobe && !o_error, o_digit_char != '0, "digit transfer with empty character")
    `RDE_ASSERT_NOW(a_error_clean, o_strobe && o_error, o_last && (o_digit_char == '0), "error transfer not marked last or carries a character")

endmodule

/* src/rde_ctrl.sv */
// ----------------------------------------------------------------------------
// rde_ctrl
// Sequencer: input check, digit division, digit readout.
// ----------------------------------------------------------------------------
module rde_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  rde_pkg::t_sts i_sts,
    output rde_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_sts.bad) begin
                        o_cmd.err = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_DIV;
                    end
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                o_cmd.wr   = i_sts.chunk_last;
                if (i_sts.chunk_last && i_sts.quo_zero) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.rd = 1'b1;
                if (i_sts.cnt_one) begin
                    o_cmd.rd_last = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* src/rde_dpath.sv */
// ----------------------------------------------------------------------------
// rde_dpath
// Radix divider (DIGIT_STEP quotient bits per cycle), digit store, output.
// ----------------------------------------------------------------------------
module rde_dpath #(
    parameter int VALUE_BITS = rde_pkg::VALUE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [rde_pkg::IN_WIDTH-1:0] i_value,
    input  logic [rde_pkg::RADIX_WIDTH-1:0]     i_radix,
    input  rde_pkg::t_cmd                       i_cmd,
    output rde_pkg::t_sts                       o_sts,
    output logic [rde_pkg::CHAR_WIDTH-1:0]      o_digit_char,
    output logic                                o_last,
    output logic                                o_error,
    output logic                                o_strobe
);

    localparam int STEP   = rde_pkg::DIGIT_STEP;
    localparam int CHUNKS = (VALUE_BITS + STEP - 1) / STEP;
    localparam int PW     = CHUNKS * STEP;
    localparam int CKW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int AW     = $clog2(VALUE_BITS);
    localparam int CW     = $clog2(VALUE_BITS + 1);
    localparam int DW     = rde_pkg::DIGIT_WIDTH;
    localparam int MAGW   = rde_pkg::IN_WIDTH - 1;

    logic [rde_pkg::RADIX_WIDTH-1:0] r_radix;
    logic [PW-1:0]                   r_quo;
    logic [PW-1:0]                   n_quo;
    logic [DW-1:0]                   r_rem;
    logic [DW-1:0]                   n_rem;
    logic [CKW-1:0]                  r_chunk;
    logic [CW-1:0]                   r_cnt;
    logic [AW-1:0]                   rd_addr;
    logic [DW-1:0]                   r_mem [VALUE_BITS];
    logic [DW-1:0]                   r_rd_data;
    logic                            r_strobe;
    logic                            r_last;
    logic                            r_err;

    // restoring division, one quotient bit per inner step
    always_comb begin
        logic [DW:0]   rem7;
        logic          qbit;
        logic [PW-1:0] work;
        logic [DW-1:0] rem;
        work = r_quo;
        rem  = r_rem;
        for (int j = 0; j < STEP; j++) begin
            rem7 = {rem, work[PW-1]};
            qbit = (rem7 >= {1'b0, r_radix});
            work = {work[PW-2:0], qbit};
            rem  = qbit ? DW'(rem7 - {1'b0, r_radix}) : rem7[DW-1:0];
        end
        n_quo = work;
        n_rem = rem;
    end

    assign rd_addr = AW'(r_cnt - CW'(1));

    assign o_sts.bad = i_value[MAGW] || (i_radix < rde_pkg::RADIX_MIN) ||
                       (i_radix > rde_pkg::RADIX_MAX) ||
                       ((i_value[MAGW-1:0] >> VALUE_BITS) != '0);
    assign o_sts.chunk_last = (r_chunk == CKW'(CHUNKS - 1));
    assign o_sts.quo_zero   = (n_quo == '0);
    assign o_sts.cnt_one    = (r_cnt == CW'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_radix <= i_radix;
            r_quo   <= PW'(i_value[MAGW-1:0]);
            r_rem   <= '0;
        end else if (i_cmd.step) begin
            r_quo <= n_quo;
            r_rem <= i_cmd.wr ? '0 : n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk  <= '0;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
            r_err    <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_chunk <= '0;
                r_cnt   <= '0;
            end else if (i_cmd.step) begin
                if (i_cmd.wr) begin
                    r_chunk <= '0;
                    r_cnt   <= r_cnt + CW'(1);
                end else begin
                    r_chunk <= r_chunk + CKW'(1);
                end
            end else if (i_cmd.rd) begin
                r_cnt <= r_cnt - CW'(1);
            end
            r_strobe <= i_cmd.rd || i_cmd.err;
            r_last   <= i_cmd.rd_last || i_cmd.err;
            r_err    <= i_cmd.err;
        end
    end

    // digit store, least significant digit at address 0
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && i_cmd.wr) begin
            r_mem[r_cnt[AW-1:0]] <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_digit_char = r_err ? '0 : rde_pkg::to_ascii(r_rd_data);
    assign o_last       = r_last;
    assign o_error      = r_err;
    assign o_strobe     = r_strobe;

endmodule
